// File: rtl/core/mmfn_pkg.sv
// ----------------------------------------------------------------------------
// mmfn_pkg
// Types and constants shared by the min-max feature normalizer and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mmfn_pkg;

    localparam int DATA_W    = 16;
    localparam int FEAT_W    = 4;
    localparam int OP_W      = 2;
    localparam int CFG_A_W   = 1;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;
    localparam int PROD_W    = 34;
    localparam int QUO_W     = 32;
    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic signed [DATA_W-1:0] TARGET_LOW_RST  = -16'sd256;
    localparam logic signed [DATA_W-1:0] TARGET_HIGH_RST = 16'sd256;

    localparam logic [CFG_A_W-1:0] CFG_TARGET_LOW  = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_TARGET_HIGH = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR     = 2'd0,
        OP_FIT       = 2'd1,
        OP_NORMALIZE = 2'd2,
        OP_REVERSE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_FIX
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/mmfn_ram.sv
// ----------------------------------------------------------------------------
// mmfn_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mmfn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/min_max_feature_normalizer.sv
// ----------------------------------------------------------------------------
// min_max_feature_normalizer
// Per-feature min-max scaler on signed Q8.8 values with a serial divider.
// ----------------------------------------------------------------------------
// A clear word finishes in its accept cycle; a fit word also passes the evaluate
// state that writes back the extremes. A normalize or reverse word goes through
// the accept cycle, a read of the stored extremes, a multiply, a magnitude step,
// the restoring divider at one quotient bit per cycle and a step to sign, offset
// and clamp the quotient; a degenerate case skips the arithmetic. The divider sets
// the rate; a finished result waits in the output register as the next word is taken.
`default_nettype none

module min_max_feature_normalizer
    import mmfn_pkg::*;
#(
    parameter int FEATURES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_axis_tdata,  // feature[3:0], value[19:4], zero
    input  wire logic [OP_W-1:0]      i_s_axis_tuser,  // op[1:0]
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic      [M_TDATA_W-1:0] o_m_axis_tdata,  // result[15:0], feature_out[19:16], zero
    output logic      [M_TUSER_W-1:0] o_m_axis_tuser,  // saturated[0], degenerate[1]
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_A_W-1:0]   i_cfg_addr,
    input  wire logic [DATA_W-1:0]    i_cfg_wdata
);

    localparam int DEPTH = (FEATURES < 16) ? FEATURES : 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_tlow, r_thigh;
    logic [DEPTH-1:0]         r_seen;
    logic                     r_out_valid;

    t_op                      r_op;
    logic [FEAT_W-1:0]        r_feat;
    logic                     r_fvalid;
    logic signed [DATA_W-1:0] r_x;
    logic signed [16:0]       r_ma, r_mb;
    logic [DATA_W-1:0]        r_div;
    logic                     r_dneg, r_neg, r_deg;
    logic signed [DATA_W-1:0] r_base;
    logic signed [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]         r_quo;
    logic [DATA_W-1:0]        r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0] r_res;
    logic [FEAT_W-1:0]        r_fout;
    logic                     r_sat, r_deg_out;

    logic                     in_acc, ram_we, load_out, div_last;
    logic [FEAT_W-1:0]        in_feat;
    logic [IDX_W-1:0]         idx;
    logic [2*DATA_W-1:0]      rd_data, wr_data;
    logic signed [DATA_W-1:0] mn, mx, new_mn, new_mx;
    logic                     seen, seed, deg;
    logic signed [16:0]       span, range_v, ea, eb, ediv;
    logic [16:0]              div_abs;
    logic [16:0]              shifted;
    logic [17:0]              trial;
    logic signed [PROD_W-1:0] q_s, sum;
    logic signed [DATA_W-1:0] fix_res;
    logic                     fix_sat;

    assign in_feat = i_s_axis_tdata[FEAT_W-1:0];
    assign idx     = r_feat[IDX_W-1:0];
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    mmfn_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx),
        .i_wdata (wr_data),
        .i_raddr (in_feat[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // Evaluation of the stored extremes.
    always_comb begin
        seen    = r_fvalid && r_seen[idx];
        mn      = r_fvalid ? $signed(rd_data[DATA_W-1:0]) : '0;
        mx      = r_fvalid ? $signed(rd_data[2*DATA_W-1:DATA_W]) : '0;
        seed    = !r_seen[idx];
        new_mn  = (seed || r_x < mn) ? r_x : mn;
        new_mx  = (seed || r_x > mx) ? r_x : mx;
        wr_data = {new_mx, new_mn};
        span    = 17'(r_thigh) - 17'(r_tlow);
        range_v = 17'(mx) - 17'(mn);
        if (r_op == OP_NORMALIZE) begin
            deg  = !seen || (mx == mn);
            ea   = 17'(r_x) - 17'(mn);
            eb   = span;
            ediv = range_v;
        end else begin
            deg  = !seen || (mx == mn) || (span == '0);
            ea   = 17'(r_x) - 17'(r_tlow);
            eb   = range_v;
            ediv = span;
        end
        div_abs = ediv[16] ? 17'(-ediv) : ediv;
    end

    // Divider step and final offset with clamp.
    always_comb begin
        shifted  = {r_rem, r_quo[QUO_W-1]};
        trial    = {1'b0, shifted} - {2'b00, r_div};
        div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
        q_s      = r_neg ? -$signed({2'b00, r_quo}) : $signed({2'b00, r_quo});
        sum      = q_s + PROD_W'(r_base);
        fix_sat  = 1'b0;
        fix_res  = r_base;
        if (!r_deg) begin
            if (sum > PROD_W'(32767)) begin
                fix_sat = 1'b1;
                fix_res = 16'sh7FFF;
            end else if (sum < -PROD_W'(32768)) begin
                fix_sat = 1'b1;
                fix_res = -16'sh8000;
            end else begin
                fix_res = sum[DATA_W-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && t_op'(i_s_axis_tuser) != OP_CLEAR) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_op == OP_FIT) begin
                    n_state = ST_IDLE;
                end else if (deg) begin
                    n_state = ST_FIX;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ABS;
            ST_ABS:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (load_out) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        ram_we          = (r_state == ST_EVAL) && (r_op == OP_FIT) && r_fvalid;
        load_out        = (r_state == ST_FIX) && (!r_out_valid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tlow      <= TARGET_LOW_RST;
            r_thigh     <= TARGET_HIGH_RST;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_TARGET_LOW:  r_tlow  <= $signed(i_cfg_wdata);
                    CFG_TARGET_HIGH: r_thigh <= $signed(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (in_acc && t_op'(i_s_axis_tuser) == OP_CLEAR) begin
                r_seen <= '0;
            end else if (ram_we) begin
                r_seen[idx] <= 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= t_op'(i_s_axis_tuser);
            r_feat   <= in_feat;
            r_fvalid <= (32'(in_feat) < FEATURES);
            r_x      <= $signed(i_s_axis_tdata[FEAT_W+DATA_W-1:FEAT_W]);
        end
        if (r_state == ST_EVAL) begin
            r_ma   <= ea;
            r_mb   <= eb;
            r_div  <= div_abs[DATA_W-1:0];
            r_dneg <= ediv[16];
            r_deg  <= deg;
            r_base <= (r_op == OP_NORMALIZE) ? r_tlow : mn;
        end
        if (r_state == ST_MUL) begin
            r_prod <= PROD_W'(r_ma) * PROD_W'(r_mb);
        end
        if (r_state == ST_ABS) begin
            r_quo <= r_prod[PROD_W-1] ? QUO_W'(-r_prod) : r_prod[QUO_W-1:0];
            r_neg <= r_prod[PROD_W-1] ^ r_dneg;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (r_state == ST_DIV) begin
            r_quo <= {r_quo[QUO_W-2:0], !trial[17]};
            r_rem <= trial[17] ? shifted[DATA_W-1:0] : trial[DATA_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
        if (load_out) begin
            r_res     <= fix_res;
            r_sat     <= fix_sat;
            r_deg_out <= r_deg;
            r_fout    <= r_feat;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_fout, r_res};
    assign o_m_axis_tuser  = {r_deg_out, r_sat};

endmodule

`default_nettype wire

// File: rtl/core/mmfn_checker.sv
// ----------------------------------------------------------------------------
// mmfn_checker
// Port-level checks on the min-max feature normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmfn_checker
    import mmfn_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 o_s_axis_tready,
    input wire logic [OP_W-1:0]      i_s_axis_tuser,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input wire logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_busy_after_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_s_axis_tuser != OP_CLEAR) |=> !o_s_axis_tready)
        else $error("ready while a word is in work");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(in_acc))
        else $error("result appeared one cycle after accept");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]))
        else $error("saturated and degenerate both set");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind min_max_feature_normalizer mmfn_checker u_mmfn_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// File: dv/min_max_feature_normalizer_tb.sv
// ----------------------------------------------------------------------------
// min_max_feature_normalizer_tb
// Self-checking bench for the min-max feature normalizer. A short table of
// directed words covers the corner cases, then random words run under several
// target ranges. Every result word is compared with a local model of the scaler
// or with the fixed answer of its table row; both stream sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_feature_normalizer_tb;
    import mmfn_pkg::*;

    localparam int FEATURES        = 16;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 48;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 68;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [FEAT_W-1:0]        feature;
        logic                     saturated;
        logic                     degenerate;
    } scaled_word_t;

    typedef struct packed {
        t_op                      op;
        logic [FEAT_W-1:0]        feature;
        logic signed [DATA_W-1:0] value;
        logic                     fixed_answer;
        scaled_word_t             answer;
    } stim_row_t;

    logic                 i_clk;
    logic                 i_rst_n         = 1'b0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;  // feature[3:0], value[19:4], zero
    logic [OP_W-1:0]      i_s_axis_tuser  = '0;  // op[1:0]
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;        // result[15:0], feature_out[19:16], zero
    logic [M_TUSER_W-1:0] o_m_axis_tuser;        // saturated[0], degenerate[1]
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_A_W-1:0]   i_cfg_addr      = '0;
    logic [DATA_W-1:0]    i_cfg_wdata     = '0;

    logic signed [DATA_W-1:0] scale_low  = TARGET_LOW_RST;
    logic signed [DATA_W-1:0] scale_high = TARGET_HIGH_RST;
    logic signed [DATA_W-1:0] feat_min [FEATURES];
    logic signed [DATA_W-1:0] feat_max [FEATURES];
    bit                       feat_seen [FEATURES];
    bit                       feat_written [FEATURES];

    scaled_word_t expected_scaled_q[$];
    stim_row_t    directed_rows[$];
    int           fail_count  = 0;
    int           send_burst  = 0;
    int           recv_burst  = 0;
    int           cycle_count = 0;

    min_max_feature_normalizer #(
        .FEATURES(FEATURES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < FEATURES; k++) begin
            feat_min[k] = '0;
            feat_max[k] = '0;
        end
    end

    function automatic logic signed [DATA_W-1:0] clamp_q88(input longint v, output logic sat);
        sat = 1'b1;
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        sat = 1'b0;
        return v[DATA_W-1:0];
    endfunction

    // Updates the fitted extremes and returns 1 when the word yields a result.
    function automatic bit apply_scaler_word(input t_op op, input logic [FEAT_W-1:0] f,
                                             input logic signed [DATA_W-1:0] value,
                                             output scaled_word_t w);
        int     x;
        int     mn;
        int     mx;
        int     lo;
        int     span;
        longint num;
        longint quo;
        x    = value;
        mn   = feat_min[f];
        mx   = feat_max[f];
        lo   = scale_low;
        span = int'(scale_high) - lo;
        w    = '0;
        w.feature = f;
        case (op)
            OP_CLEAR: begin
                for (int k = 0; k < FEATURES; k++) feat_seen[k] = 1'b0;
                return 1'b0;
            end
            OP_FIT: begin
                if (!feat_seen[f]) begin
                    feat_min[f]     = value;
                    feat_max[f]     = value;
                    feat_seen[f]    = 1'b1;
                    feat_written[f] = 1'b1;
                end else begin
                    if (value < feat_min[f]) feat_min[f] = value;
                    if (value > feat_max[f]) feat_max[f] = value;
                end
                return 1'b0;
            end
            OP_NORMALIZE: begin
                if (!feat_seen[f] || mx == mn) begin
                    w.result     = scale_low;
                    w.degenerate = 1'b1;
                end else begin
                    num      = longint'(x - mn) * longint'(span);
                    quo      = num / longint'(mx - mn);
                    w.result = clamp_q88(quo + lo, w.saturated);
                end
            end
            default: begin
                if (!feat_seen[f] || mx == mn || span == 0) begin
                    w.result     = feat_min[f];
                    w.degenerate = 1'b1;
                end else begin
                    num      = longint'(x - lo) * longint'(mx - mn);
                    quo      = num / longint'(span);
                    w.result = clamp_q88(quo + mn, w.saturated);
                end
            end
        endcase
        return 1'b1;
    endfunction

    // Idle cycles before the next word, with occasional back-to-back bursts.
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(4, 24);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic void add_row(input t_op op, input logic [FEAT_W-1:0] f,
                                    input logic signed [DATA_W-1:0] value, input bit fixed,
                                    input logic signed [DATA_W-1:0] res, input bit deg);
        stim_row_t row;
        row.op                = op;
        row.feature           = f;
        row.value             = value;
        row.fixed_answer      = fixed;
        row.answer.result     = res;
        row.answer.feature    = f;
        row.answer.saturated  = 1'b0;
        row.answer.degenerate = deg;
        directed_rows = {directed_rows, row};
    endfunction

    task automatic send_word(input stim_row_t row);
        int           gap;
        bit           has_result;
        scaled_word_t w;
        gap = draw_wait(send_burst);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W - FEAT_W - DATA_W){1'b0}}, row.value, row.feature};
        i_s_axis_tuser  <= row.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        has_result = apply_scaler_word(row.op, row.feature, row.value, w);
        if (has_result) begin
            expected_scaled_q = {expected_scaled_q, row.fixed_answer ? row.answer : w};
        end
    endtask

    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (expected_scaled_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_targets(input logic signed [DATA_W-1:0] lo,
                                 input logic signed [DATA_W-1:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_TARGET_LOW;
        i_cfg_wdata <= lo;
        @(posedge i_clk);
        scale_low = lo;
        i_cfg_addr  <= CFG_TARGET_HIGH;
        i_cfg_wdata <= hi;
        @(posedge i_clk);
        scale_high = hi;
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int           stall;
        scaled_word_t want;
        scaled_word_t got;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = draw_wait(recv_burst);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got.result     = o_m_axis_tdata[DATA_W-1:0];
            got.feature    = o_m_axis_tdata[DATA_W+FEAT_W-1:DATA_W];
            got.saturated  = o_m_axis_tuser[0];
            got.degenerate = o_m_axis_tuser[1];
            if (expected_scaled_q.size() == 0) begin
                $error("unexpected result word: result %0d, feature_out %0d",
                       got.result, got.feature);
                fail_count++;
            end else begin
                want = expected_scaled_q.pop_front();
                if (got.result !== want.result) begin
                    $error("result: expected %0d, got %0d", want.result, got.result);
                    fail_count++;
                end
                if (got.feature !== want.feature) begin
                    $error("feature_out: expected %0d, got %0d", want.feature, got.feature);
                    fail_count++;
                end
                if (got.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b", want.saturated, got.saturated);
                    fail_count++;
                end
                if (got.degenerate !== want.degenerate) begin
                    $error("degenerate: expected %0b, got %0b", want.degenerate,
                           got.degenerate);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        stim_row_t                row;
        int                       pick;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic [FEAT_W-1:0]        f;
        logic [DATA_W-1:0]        v;

        // Directed words under the reset targets of -1.0 and +1.0.
        add_row(OP_NORMALIZE,  0,      0, 1,   -256, 1);
        add_row(OP_FIT,        0, -32768, 0,      0, 0);
        add_row(OP_NORMALIZE,  0,    100, 1,   -256, 1);
        add_row(OP_REVERSE,    0,      5, 1, -32768, 1);
        add_row(OP_FIT,        0,  32767, 0,      0, 0);
        add_row(OP_NORMALIZE,  0, -32768, 1,   -256, 0);
        add_row(OP_NORMALIZE,  0,  32767, 1,    256, 0);
        add_row(OP_NORMALIZE,  0,      0, 0,      0, 0);
        add_row(OP_REVERSE,    0,   -256, 1, -32768, 0);
        add_row(OP_REVERSE,    0,    256, 1,  32767, 0);
        add_row(OP_REVERSE,    0,  32767, 0,      0, 0);
        add_row(OP_REVERSE,    0, -32768, 0,      0, 0);
        add_row(OP_FIT,       15,    256, 0,      0, 0);
        add_row(OP_FIT,       15,   -256, 0,      0, 0);
        add_row(OP_FIT,       15,      0, 0,      0, 0);
        add_row(OP_NORMALIZE, 15,   -100, 0,      0, 0);
        add_row(OP_REVERSE,   15,    100, 0,      0, 0);
        add_row(OP_FIT,        7,      0, 0,      0, 0);
        add_row(OP_FIT,        7,      1, 0,      0, 0);
        add_row(OP_NORMALIZE,  7,  32767, 0,      0, 0);
        add_row(OP_NORMALIZE,  7, -32768, 0,      0, 0);
        add_row(OP_CLEAR,      9,      0, 0,      0, 0);
        add_row(OP_NORMALIZE,  0,      0, 1,   -256, 1);
        add_row(OP_REVERSE,   15,      0, 1,   -256, 1);
        add_row(OP_FIT,       15,   1000, 0,      0, 0);
        add_row(OP_REVERSE,   15,      0, 1,   1000, 1);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) send_word(directed_rows[k]);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_block();
            case (phase)
                0: begin
                    lo = 16'sh8000;
                    hi = 16'sh7fff;
                end
                1: begin
                    lo = 16'sh7fff;
                    hi = 16'sh8000;
                end
                2: begin
                    lo = DATA_W'($urandom);
                    hi = lo;
                end
                3: begin
                    lo = 16'sd0;
                    hi = 16'sd256;
                end
                default: begin
                    lo = DATA_W'($urandom);
                    hi = DATA_W'($urandom);
                end
            endcase
            write_targets(lo, hi);

            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                pick = $urandom_range(0, 99);
                f = FEAT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                         : $urandom_range(0, 3));
                case ($urandom_range(0, 7))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = DATA_W'($urandom_range(0, 1023) - 512);
                    default: v = DATA_W'($urandom);
                endcase
                row         = '0;
                row.feature = f;
                row.value   = v;
                if (pick < 3) begin
                    row.op = OP_CLEAR;
                end else if (pick < 40) begin
                    row.op = OP_FIT;
                end else if (pick < 72) begin
                    row.op = OP_NORMALIZE;
                end else begin
                    row.op = OP_REVERSE;
                end
                // A feature whose extremes were never stored has no defined minimum to return.
                if (row.op == OP_REVERSE && !feat_written[f]) row.op = OP_NORMALIZE;
                send_word(row);
            end
        end

        settle_block();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
